### design/b64d_pkg.sv
// Package for the dotted base64url encoder.
// Holds field widths, character constants and the 6-bit symbol lookup.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CharW    = 7;
  localparam int unsigned SymW     = 6;
  localparam int unsigned CountW   = 9;
  localparam int unsigned MaxChars = 5;
  localparam int unsigned RemW     = $clog2(MaxChars + 1);

  localparam logic [CharW-1:0] DOT_CHAR          = 7'h2E;
  localparam logic [ByteW-1:0] DOT_SPACING_RESET = 8'd60;

  typedef logic [CharW-1:0] char_t;
  typedef logic [RemW-1:0]  rem_t;

  // Map a 6-bit value onto A-Z a-z 0-9 - _
  function automatic char_t b64_sym(input logic [SymW-1:0] v);
    char_t c;
    c = '0;
    if (v < 6'd26) begin
      c = 7'h41 + {1'b0, v};
    end else if (v < 6'd52) begin
      c = 7'h61 + {1'b0, v} - 7'd26;
    end else if (v < 6'd62) begin
      c = 7'h30 + {1'b0, v} - 7'd52;
    end else if (v == 6'd62) begin
      c = 7'h2D;
    end else begin
      c = 7'h5F;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### design/base64url_encoder_dotted.sv
// Top level of the dotted base64url encoder.
// Uses b64d_pkg for widths, character constants and the symbol lookup.
//
// Usage:
//   Input stream (in_*): one message byte per transaction in in_tdata,
//   in_tlast set on the final byte of a message.
//   Output stream (out_*): one ASCII character per transaction in
//   out_tdata[6:0], out_tlast set on the final character of a message.
//   Config (cfg_*): cfg_data written to the dot spacing at cfg_valid;
//   cfg_ready is always high. Write only while the block is idle.
// Timing:
//   Each accepted byte is encoded into a group register of up to five
//   characters (four symbols plus an optional dot, or two or three
//   symbols at a message end). Characters then leave through the output
//   register at one per cycle while out_tready is high. The first character
//   of a group passes the group register and then the output register
//   before it is presented on out_*. A byte that completes a group keeps
//   in_tready low until the group's last character moves to the output
//   register; bytes that complete nothing are taken at a byte per cycle.
// Reset: clears pending bytes, phase, dot counter and both stream stages;
//   dot spacing returns to 60.
// Stall: with out_tready low the output register holds its character; the
//   group register keeps the rest and in_tready drops until its last character moves out.
`timescale 1ns / 1ps
`default_nettype none

module base64url_encoder_dotted
  import b64d_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // input stream
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [ByteW-1:0] in_tdata,   // [7:0] data_byte
  input  wire logic             in_tlast,   // last_byte
  // output stream
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [7:0]            out_tdata,  // [6:0] out_char, [7] zero
  output logic                  out_tlast,  // last_char
  // config write
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [ByteW-1:0] cfg_data    // dot_spacing
);

  // encoder state
  logic [15:0]       pend_r, pend_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic [CountW-1:0] csd_r, csd_nxt;
  logic [ByteW-1:0]  spacing_r;

  // character group buffer
  char_t             grp_r [MaxChars];
  char_t             grp_nxt [MaxChars];
  rem_t              rem_r, cnt_nxt;
  logic              grp_last_r;

  // output register
  char_t             out_char_r;
  logic              out_last_r;
  logic              out_valid_r;

  logic              in_acc, out_free, move;
  logic [ByteW-1:0]  b0, b1, b2;
  logic [CountW-1:0] sum;
  logic              dot;

  assign out_free  = !out_valid_r || out_tready;
  assign move      = (rem_r != '0) && out_free;
  assign in_tready = (rem_r == '0) || ((rem_r == rem_t'(1)) && move);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tlast  = out_last_r;

  // Byte lanes of the group as seen after this byte; missing bytes are zero,
  // which gives the zero fill of a final partial group.
  always_comb begin
    b0 = (phase_r == 2'd0) ? in_tdata : pend_r[15:8];
    b1 = (phase_r == 2'd0) ? '0 : ((phase_r == 2'd1) ? in_tdata : pend_r[7:0]);
    b2 = (phase_r[1]) ? in_tdata : '0;
  end

  assign sum = csd_r + CountW'(4);
  assign dot = sum > {1'b0, spacing_r};

  always_comb begin
    grp_nxt[0] = b64_sym(b0[7:2]);
    grp_nxt[1] = b64_sym({b0[1:0], b1[7:4]});
    grp_nxt[2] = b64_sym({b1[3:0], b2[7:6]});
    grp_nxt[3] = b64_sym(b2[5:0]);
    grp_nxt[4] = DOT_CHAR;

    pend_nxt  = pend_r;
    phase_nxt = phase_r;
    csd_nxt   = csd_r;
    cnt_nxt   = '0;
    case (phase_r)
      2'd0: begin
        pend_nxt  = {in_tdata, 8'h00};
        phase_nxt = 2'd1;
        cnt_nxt   = in_tlast ? rem_t'(2) : '0;
      end
      2'd1: begin
        pend_nxt  = {pend_r[15:8], in_tdata};
        phase_nxt = 2'd2;
        cnt_nxt   = in_tlast ? rem_t'(3) : '0;
      end
      default: begin
        pend_nxt  = '0;
        phase_nxt = 2'd0;
        csd_nxt   = dot ? '0 : sum;
        cnt_nxt   = dot ? rem_t'(5) : rem_t'(4);
      end
    endcase
    // message end restarts pending bytes, phase and dot counter
    if (in_tlast) begin
      pend_nxt  = '0;
      phase_nxt = 2'd0;
      csd_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      phase_r     <= '0;
      csd_r       <= '0;
      spacing_r   <= DOT_SPACING_RESET;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        spacing_r <= cfg_data;
      end
      if (in_acc) begin
        pend_r  <= pend_nxt;
        phase_r <= phase_nxt;
        csd_r   <= csd_nxt;
        rem_r   <= cnt_nxt;
      end else if (move) begin
        rem_r <= rem_r - rem_t'(1);
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < MaxChars; i++) begin
        grp_r[i] <= grp_nxt[i];
      end
      grp_last_r <= in_tlast;
    end else if (move) begin
      for (int i = 0; i < MaxChars - 1; i++) begin
        grp_r[i] <= grp_r[i+1];
      end
    end
    if (move) begin
      out_char_r <= grp_r[0];
      out_last_r <= (rem_r == rem_t'(1)) && grp_last_r;
    end
  end

endmodule

`default_nettype wire

### design/b64d_checker.sv
// Port-level checker for the dotted base64url encoder, bound to the top level.
// Imports b64d_pkg; the ports use literal widths.
`timescale 1ns / 1ps
`default_nettype none

module b64d_checker
  import b64d_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [7:0]       out_tdata,
  input wire logic             out_tlast
);

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // characters are 7-bit ASCII
  a_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[7])
    else $error("out_tdata bit 7 set");

  // nothing pending right after reset
  a_reset_empty: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_tvalid && in_tready)
    else $error("stream stages not empty after reset");

  // input only waits while a character is presented or a group was just loaded
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid || $past(in_tvalid && in_tready))
    else $error("input stalled with output idle");

endmodule

bind base64url_encoder_dotted b64d_checker u_b64d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire
